>>> sv/mqphi_pkg.sv
// shared types and constants for the multi-queue bank with urgent head insert
// no dependencies; imported by multi_queue_priority_head_insert
`default_nettype none

package mqphi_pkg;

    localparam int NUM_QUEUES  = 32;
    localparam int QUEUE_DEPTH = 8;
    localparam int TAG_BITS    = 16;

    localparam int QSEL_W    = 5;
    localparam int STATUS_W  = 2;
    localparam int OCC_W     = 4;
    localparam int TDATA_IN  = 16;
    localparam int TUSER_IN  = 7;
    localparam int TDATA_OUT = 24;

    localparam int QIDX_W    = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int PTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int COUNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W     = COUNT_W + 1;
    localparam int MEM_DEPTH = NUM_QUEUES * QUEUE_DEPTH;
    localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

    typedef logic [TAG_BITS-1:0] tag_t;
    typedef logic [PTR_W-1:0]    ptr_t;
    typedef logic [COUNT_W-1:0]  count_t;
    typedef logic [QIDX_W-1:0]   qidx_t;
    typedef logic [ADDR_W-1:0]   addr_t;

    typedef struct packed {
        logic urgent;
        tag_t tag;
    } entry_t;

    typedef enum logic [0:0] {
        REQ_ADD  = 1'b0,
        REQ_TAKE = 1'b1
    } req_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_DONE  = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

>>> sv/multi_queue_priority_head_insert.sv
// bank of bounded queues kept as circular buffers in one entry memory
// one request at a time, through idle, compute and deliver states, with a single shared
// pointer adder and a one-port entry memory; deliver waits while the result is held
// reset: queue counts and head pointers cleared at once, entry memory not cleared
// depends on mqphi_pkg
`default_nettype none

module multi_queue_priority_head_insert
    import mqphi_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [TDATA_IN-1:0]  s_tdata,   // entry_tag[15:0]
    input  wire logic [TUSER_IN-1:0]  s_tuser,   // req_type[0], queue_sel[5:1], urgent[6]
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [TDATA_OUT-1:0]      m_tdata,   // tag_out[15:0], urgent_out[16], occupancy[20:17]
    output logic [STATUS_W-1:0]       m_tuser    // op_status[1:0]
);

    state_t state_reg, state_next;

    logic              take_reg;
    logic [QSEL_W-1:0] qsel_reg;
    logic              urgent_reg;
    tag_t              tag_reg;

    count_t count_reg [NUM_QUEUES];
    ptr_t   head_reg  [NUM_QUEUES];

    entry_t mem [MEM_DEPTH];
    entry_t rd_data_reg;

    status_t status_reg, status_next;
    count_t  occ_reg, occ_next;
    logic    take_ok_reg, take_ok_next;

    logic                 m_tvalid_reg, m_tvalid_next;
    logic [TDATA_OUT-1:0] m_tdata_reg, m_tdata_next;
    logic [STATUS_W-1:0]  m_tuser_reg, m_tuser_next;

    logic   in_range;
    qidx_t  q_idx;
    count_t cur_count;
    ptr_t   cur_head;
    count_t add_opnd;
    logic [SUM_W-1:0] ptr_sum;
    ptr_t   ptr_new;
    logic   mem_we, mem_re, q_upd;
    addr_t  mem_addr;
    count_t count_new;
    ptr_t   head_new;
    tag_t   tag_res;
    logic   urg_res;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // queue lookup and the shared wrap-around pointer adder
    always_comb begin
        in_range  = (int'(qsel_reg) < NUM_QUEUES);
        q_idx     = QIDX_W'(qsel_reg);
        cur_count = count_reg[q_idx];
        cur_head  = head_reg[q_idx];
        if (take_reg == REQ_TAKE) begin
            add_opnd = COUNT_W'(1);
        end else if (urgent_reg) begin
            add_opnd = COUNT_W'(QUEUE_DEPTH - 1);
        end else begin
            add_opnd = cur_count;
        end
        ptr_sum = SUM_W'(cur_head) + SUM_W'(add_opnd);
        if (ptr_sum >= SUM_W'(QUEUE_DEPTH)) begin
            ptr_sum = ptr_sum - SUM_W'(QUEUE_DEPTH);
        end
        ptr_new = PTR_W'(ptr_sum);
    end

    always_comb begin
        state_next    = state_reg;
        status_next   = status_reg;
        occ_next      = occ_reg;
        take_ok_next  = take_ok_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        mem_we        = 1'b0;
        mem_re        = 1'b0;
        q_upd         = 1'b0;
        count_new     = cur_count;
        head_new      = cur_head;
        mem_addr      = ADDR_W'(int'(q_idx) * QUEUE_DEPTH + int'(ptr_new));
        tag_res       = '0;
        urg_res       = 1'b0;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC: begin
                state_next   = ST_DONE;
                status_next  = STAT_DONE;
                take_ok_next = 1'b0;
                occ_next     = '0;
                if (!in_range) begin
                    status_next = (take_reg == REQ_TAKE) ? STAT_EMPTY : STAT_FULL;
                end else if (take_reg == REQ_TAKE) begin
                    if (cur_count == '0) begin
                        status_next = STAT_EMPTY;
                    end else begin
                        mem_re       = 1'b1;
                        mem_addr     = ADDR_W'(int'(q_idx) * QUEUE_DEPTH + int'(cur_head));
                        q_upd        = 1'b1;
                        head_new     = ptr_new;
                        count_new    = cur_count - COUNT_W'(1);
                        take_ok_next = 1'b1;
                        occ_next     = count_new;
                    end
                end else begin
                    if (cur_count >= COUNT_W'(QUEUE_DEPTH)) begin
                        status_next = STAT_FULL;
                        occ_next    = cur_count;
                    end else begin
                        mem_we    = 1'b1;
                        q_upd     = 1'b1;
                        count_new = cur_count + COUNT_W'(1);
                        if (urgent_reg) begin
                            head_new = ptr_new;
                        end
                        occ_next = count_new;
                    end
                end
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    if (take_ok_reg) begin
                        tag_res = rd_data_reg.tag;
                        urg_res = rd_data_reg.urgent;
                    end
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {3'b000, OCC_W'(occ_reg), urg_res, 16'(tag_res)};
                    m_tuser_next  = status_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            take_reg   <= s_tuser[0];
            qsel_reg   <= s_tuser[QSEL_W:1];
            urgent_reg <= s_tuser[QSEL_W+1];
            tag_reg    <= TAG_BITS'(s_tdata);
        end
        status_reg  <= status_next;
        occ_reg     <= occ_next;
        take_ok_reg <= take_ok_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_QUEUES; i++) begin
                count_reg[i] <= '0;
                head_reg[i]  <= '0;
            end
        end else if (q_upd) begin
            count_reg[q_idx] <= count_new;
            head_reg[q_idx]  <= head_new;
        end
    end

    // entry memory, one write or one registered read per cycle
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_addr] <= '{urgent: urgent_reg, tag: tag_reg};
        end
        if (mem_re) begin
            rd_data_reg <= mem[mem_addr];
        end
    end

    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[20:17] <= OCC_W'(QUEUE_DEPTH)))
        else $error("occupancy above queue depth");

    a_empty_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == STAT_EMPTY)) |-> (m_tdata[20:0] == '0))
        else $error("empty take carries data");

    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("item overlap after accept");

    a_mem_access: assert property (@(posedge aclk) disable iff (!aresetn)
        (mem_we || mem_re) |-> (state_reg == ST_CALC && !(mem_we && mem_re)))
        else $error("memory access outside compute step");

endmodule

`default_nettype wire

>>> bench/queue_bank_checker.sv
// checker for the queue bank: predicts every result from the accepted requests
// and compares the results seen on the master side in order
// depends on mqphi_pkg; instantiated by tb
module queue_bank_checker
    import mqphi_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    input  wire logic                 s_tready,
    input  wire logic [TDATA_IN-1:0]  s_tdata,   // entry_tag[15:0]
    input  wire logic [TUSER_IN-1:0]  s_tuser,   // req_type[0], queue_sel[5:1], urgent[6]
    input  wire logic                 m_tvalid,
    input  wire logic                 m_tready,
    input  wire logic [TDATA_OUT-1:0] m_tdata,   // tag_out[15:0], urgent_out[16], occupancy[20:17]
    input  wire logic [STATUS_W-1:0]  m_tuser,   // op_status[1:0]
    output int                        fail_count,
    output int                        answers_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        status_t          status;
        logic [15:0]      tag;
        logic             urgent;
        logic [OCC_W-1:0] occ;
    } answer_t;

    tag_t    bank_tag  [NUM_QUEUES][QUEUE_DEPTH];
    logic    bank_mark [NUM_QUEUES][QUEUE_DEPTH];
    int      bank_fill [NUM_QUEUES];
    answer_t answers_due[$];
    int      errors = 0;

    assign fail_count = errors;

    function automatic answer_t bank_answer(req_t kind, int q, logic urg, logic [15:0] tag_in);
        answer_t a;
        int n;
        a.status = STAT_DONE;
        a.tag    = '0;
        a.urgent = 1'b0;
        a.occ    = '0;
        if (q >= NUM_QUEUES) begin
            a.status = (kind == REQ_TAKE) ? STAT_EMPTY : STAT_FULL;
            return a;
        end
        n = bank_fill[q];
        if (kind == REQ_ADD) begin
            if (n >= QUEUE_DEPTH) begin
                a.status = STAT_FULL;
            end else if (urg) begin
                for (int i = n; i > 0; i--) begin
                    bank_tag[q][i]  = bank_tag[q][i-1];
                    bank_mark[q][i] = bank_mark[q][i-1];
                end
                bank_tag[q][0]  = tag_t'(tag_in);
                bank_mark[q][0] = urg;
                n++;
            end else begin
                bank_tag[q][n]  = tag_t'(tag_in);
                bank_mark[q][n] = urg;
                n++;
            end
        end else begin
            if (n == 0) begin
                a.status = STAT_EMPTY;
            end else begin
                a.tag    = 16'(bank_tag[q][0]);
                a.urgent = bank_mark[q][0];
                // remaining entries move one place toward the head
                for (int i = 0; i + 1 < n; i++) begin
                    bank_tag[q][i]  = bank_tag[q][i+1];
                    bank_mark[q][i] = bank_mark[q][i+1];
                end
                n--;
            end
        end
        bank_fill[q] = n;
        a.occ = OCC_W'(n);
        return a;
    endfunction

    always @(posedge aclk) begin
        answer_t want;
        if (!aresetn) begin
            answers_due.delete();
            foreach (bank_fill[q]) bank_fill[q] = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                answers_due.push_back(bank_answer(req_t'(s_tuser[0]), int'(s_tuser[5:1]),
                                                  s_tuser[6], s_tdata[15:0]));
            end
            if (m_tvalid && m_tready) begin
                if (answers_due.size() == 0) begin
                    $display("%0t: result with nothing due, tdata %h tuser %h",
                             $time, m_tdata, m_tuser);
                    errors++;
                end else begin
                    want = answers_due.pop_front();
                    if (m_tuser !== want.status) begin
                        $display("%0t: op_status expected %0d got %0d",
                                 $time, want.status, m_tuser);
                        errors++;
                    end
                    if (m_tdata[15:0] !== want.tag) begin
                        $display("%0t: tag_out expected %h got %h",
                                 $time, want.tag, m_tdata[15:0]);
                        errors++;
                    end
                    if (m_tdata[16] !== want.urgent) begin
                        $display("%0t: urgent_out expected %b got %b",
                                 $time, want.urgent, m_tdata[16]);
                        errors++;
                    end
                    if (m_tdata[20:17] !== want.occ) begin
                        $display("%0t: occupancy expected %0d got %0d",
                                 $time, want.occ, m_tdata[20:17]);
                        errors++;
                    end
                end
            end
        end
        answers_pending <= answers_due.size();
    end

endmodule

>>> bench/tb.sv
// top of the queue bank bench: clock, reset, request stimulus and result back-pressure
// checking sits in queue_bank_checker; depends on mqphi_pkg and the block itself
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import mqphi_pkg::*;

    localparam int CYCLE_LIMIT = 150000;
    localparam int SETTLE      = 8;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [TDATA_IN-1:0]  s_tdata  = '0;   // entry_tag[15:0]
    logic [TUSER_IN-1:0]  s_tuser  = '0;   // req_type[0], queue_sel[5:1], urgent[6]
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [TDATA_OUT-1:0] m_tdata;         // tag_out[15:0], urgent_out[16], occupancy[20:17]
    logic [STATUS_W-1:0]  m_tuser;         // op_status[1:0]
    int                   fail_count;
    int                   answers_pending;
    int                   cycles = 0;
    bit                   send_calm = 1'b0;
    bit                   recv_calm = 1'b0;

    multi_queue_priority_head_insert dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    queue_bank_checker checker_i (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .fail_count      (fail_count),
        .answers_pending (answers_pending)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("[multi_queue_priority_head_insert] ERROR");
            $finish;
        end
    end

    // result side back-pressure
    initial begin
        int stall;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            stall = recv_calm ? 0 : $urandom_range(0, 7);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    task automatic send_request(req_t kind, int q, logic urg, logic [15:0] tag);
        int gap;
        gap = send_calm ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= tag;
        s_tuser  <= {urg, QSEL_W'(q), kind};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic drain_answers();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (answers_pending != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    initial begin
        int       hot[4];
        int       add_bias;
        int       q;
        int       pick;
        req_t     kind;
        logic     urg;
        logic [15:0] tag;
        logic [15:0] fill_tags[8];
        logic        fill_urg[8];

        fill_tags = '{16'h0001, 16'hFFFF, 16'h8000, 16'h0000,
                      16'h5A5A, 16'hA5A5, 16'h7FFF, 16'h1234};
        fill_urg  = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0};

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (3) @(posedge aclk);

        // take from an empty queue
        send_request(REQ_TAKE, 0, 1'b0, 16'h0000);
        // fill the top queue with mixed head and tail inserts
        for (int i = 0; i < 8; i++) send_request(REQ_ADD, 31, fill_urg[i], fill_tags[i]);
        // adds to a full queue are refused
        send_request(REQ_ADD, 31, 1'b0, 16'h4321);
        send_request(REQ_ADD, 31, 1'b1, 16'hFFFF);
        // take from a full queue, then empty it and take once more
        for (int i = 0; i < 9; i++) send_request(REQ_TAKE, 31, 1'b1, 16'hFFFF);
        send_request(REQ_ADD, 0, 1'b1, 16'hFFFF);
        send_request(REQ_TAKE, 0, 1'b0, 16'h0000);
        drain_answers();

        for (int blk = 0; blk < 21; blk++) begin
            foreach (hot[i]) hot[i] = $urandom_range(0, 31);
            case ($urandom_range(0, 2))
                0: begin
                    add_bias = 75;
                end
                1: begin
                    add_bias = 30;
                end
                default: begin
                    add_bias = 50;
                end
            endcase
            send_calm = ($urandom_range(0, 3) == 0);
            recv_calm = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < 50; k++) begin
                q    = ($urandom_range(0, 9) < 8) ? hot[$urandom_range(0, 3)]
                                                  : $urandom_range(0, 31);
                kind = ($urandom_range(0, 99) < add_bias) ? REQ_ADD : REQ_TAKE;
                urg  = ($urandom_range(0, 3) == 0);
                pick = $urandom_range(0, 15);
                if (pick == 0) begin
                    tag = 16'h0000;
                end else if (pick == 1) begin
                    tag = 16'hFFFF;
                end else begin
                    tag = 16'($urandom_range(0, 65535));
                end
                send_request(kind, q, urg, tag);
            end
            if (blk % 5 == 4) drain_answers();
        end
        send_calm = 1'b0;
        recv_calm = 1'b0;

        drain_answers();
        if (fail_count == 0 && answers_pending == 0) begin
            $display("[multi_queue_priority_head_insert] OK");
        end else begin
            $display("[multi_queue_priority_head_insert] ERROR");
        end
        $finish;
    end

endmodule
